[design/mle_pkg.sv]
package mle_pkg;

  localparam logic [15:0] UNIT_TICKS_RESET = 16'd500;
  localparam logic [7:0]  FIRST_LETTER     = 8'h61;
  localparam logic [7:0]  LAST_LETTER      = 8'h7A;
  localparam int          DUR_W            = 18;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ON,
    ST_OFF,
    ST_GAP,
    ST_END
  } state_t;

  typedef enum logic [1:0] {
    UNITS_1,
    UNITS_2,
    UNITS_4
  } units_t;

  // One interval request from the sequencer to the output stage
  typedef struct packed {
    logic   valid;
    logic   lamp;
    units_t units;
    logic   last;
  } emit_t;

  // High nibble: element count. Low nibble: elements, first in highest used bit, 1 = dash.
  function automatic logic [7:0] letter_code(input logic [4:0] idx);
    logic [7:0] code;
    case (idx)
      5'd0:  code = 8'h21;
      5'd1:  code = 8'h48;
      5'd2:  code = 8'h4A;
      5'd3:  code = 8'h34;
      5'd4:  code = 8'h10;
      5'd5:  code = 8'h42;
      5'd6:  code = 8'h36;
      5'd7:  code = 8'h40;
      5'd8:  code = 8'h20;
      5'd9:  code = 8'h47;
      5'd10: code = 8'h35;
      5'd11: code = 8'h44;
      5'd12: code = 8'h23;
      5'd13: code = 8'h22;
      5'd14: code = 8'h37;
      5'd15: code = 8'h46;
      5'd16: code = 8'h4D;
      5'd17: code = 8'h32;
      5'd18: code = 8'h30;
      5'd19: code = 8'h11;
      5'd20: code = 8'h31;
      5'd21: code = 8'h41;
      5'd22: code = 8'h33;
      5'd23: code = 8'h49;
      5'd24: code = 8'h4B;
      5'd25: code = 8'h4C;
      default: code = 8'h10;
    endcase
    return code;
  endfunction

endpackage

[design/mle_dur.sv]
module mle_dur import mle_pkg::*; (
  input  logic [15:0]      unit_ticks,
  input  units_t           units,
  output logic [DUR_W-1:0] dur
);

  logic [DUR_W-1:0] base;

  assign base = {2'b00, unit_ticks};

  always_comb begin
    case (units)
      UNITS_1: dur = base;
      UNITS_2: dur = {base[DUR_W-2:0], 1'b0};
      UNITS_4: dur = {base[DUR_W-3:0], 2'b00};
      default: dur = base;
    endcase
  end

endmodule

[design/mle_seq.sv]
module mle_seq import mle_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] char_code,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       slot_free,
  output emit_t      emit
);

  state_t     state, state_next;
  logic [3:0] elems, elems_next;
  logic [1:0] left, left_next;

  logic [7:0] offset;
  logic [7:0] code;
  logic [3:0] aligned;
  logic       is_letter;
  logic       step;

  assign offset    = char_code - FIRST_LETTER;
  assign code      = letter_code(offset[4:0]);
  assign is_letter = (char_code >= FIRST_LETTER) && (char_code <= LAST_LETTER);
  assign in_ready  = (state == ST_IDLE);
  assign step      = emit.valid && slot_free;

  // Left-align the element bits so the first element sits in bit 3
  always_comb begin
    case (code[6:4])
      3'd1:    aligned = {code[0], 3'b000};
      3'd2:    aligned = {code[1:0], 2'b00};
      3'd3:    aligned = {code[2:0], 1'b0};
      default: aligned = code[3:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
    elems <= elems_next;
    left  <= left_next;
  end

  always_comb begin
    state_next = state;
    elems_next = elems;
    left_next  = left;
    emit       = '{valid: 1'b0, lamp: 1'b0, units: UNITS_1, last: 1'b0};
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          elems_next = aligned;
          left_next  = 2'(code[6:4] - 3'd1);
          state_next = is_letter ? ST_ON : ST_GAP;
        end
      end
      ST_ON: begin
        emit = '{valid: 1'b1, lamp: 1'b1, units: (elems[3] ? UNITS_2 : UNITS_1), last: 1'b0};
        if (step) begin
          state_next = ST_OFF;
        end
      end
      ST_OFF: begin
        emit = '{valid: 1'b1, lamp: 1'b0, units: UNITS_1, last: 1'b0};
        if (step) begin
          elems_next = {elems[2:0], 1'b0};
          left_next  = left - 2'd1;
          state_next = (left == 2'd0) ? ST_END : ST_ON;
        end
      end
      ST_GAP: begin
        emit = '{valid: 1'b1, lamp: 1'b0, units: UNITS_4, last: 1'b0};
        if (step) begin
          state_next = ST_END;
        end
      end
      ST_END: begin
        emit = '{valid: 1'b1, lamp: 1'b0, units: UNITS_2, last: 1'b1};
        if (step) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[design/morse_letter_encoder.sv]
// Morse letter keyer: one character byte in, a run of lamp intervals out.
//
// Input channel: char_code with in_valid / in_ready. A lower-case letter
// gives an on/off pair per element (dot one unit, dash two units, then one
// unit off); any other byte gives a single four-unit off interval. Every
// character closes with a two-unit off interval flagged by last.
// Output channel: lamp_on, duration_ticks, last with out_valid / out_ready.
// duration_ticks is the unit count times unit_ticks.
// Config: unit_ticks is written on any cycle with unit_ticks_we high.
//
// Timing: an accepted character takes the sequencer out of idle, then its
// first interval is loaded into the output register, then one interval per
// cycle while the receiver takes them, with the sequencer stepping through
// the shared duration shifter. in_ready is high only while the sequencer is
// idle; it may take the next character while the final beat still waits.
// A receiver stall holds the output register and freezes the sequencer.
// Reset clears the sequencer and output valid, and sets unit_ticks to 500.
module morse_letter_encoder import mle_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             unit_ticks_we,
  input  logic [15:0]      unit_ticks_data,
  input  logic [7:0]       char_code,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             lamp_on,
  output logic [DUR_W-1:0] duration_ticks,
  output logic             last,
  output logic             out_valid,
  input  logic             out_ready
);

  logic [15:0]      unit_ticks;
  emit_t            emit;
  logic             slot_free;
  logic [DUR_W-1:0] dur;

  // Output slot is free when empty or being drained this cycle
  assign slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_ticks <= UNIT_TICKS_RESET;
    end else if (unit_ticks_we) begin
      unit_ticks <= unit_ticks_data;
    end
  end

  mle_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .char_code (char_code),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .slot_free (slot_free),
    .emit      (emit)
  );

  // Shared duration unit: scale the unit length by 1, 2 or 4
  mle_dur u_dur (
    .unit_ticks (unit_ticks),
    .units      (emit.units),
    .dur        (dur)
  );

  // Output register: load a new beat when the slot is free, else hold
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (slot_free) begin
      out_valid <= emit.valid;
    end
    if (slot_free && emit.valid) begin
      lamp_on        <= emit.lamp;
      duration_ticks <= dur;
      last           <= emit.last;
    end
  end

endmodule

[tb/tb_top.sv]
module tb_top;
  import mle_pkg::*;

  // Cycles with no beat on either channel before the run is declared hung.
  localparam int STALL_LIMIT  = 2000;
  // Receiver hold-off used to back the block up into its input.
  localparam int HOLD_CYCLES  = 200;
  // Quiet cycles after the last expected interval.
  localparam int SETTLE_CYCLES = 12;

  typedef struct packed {
    logic             lamp;
    logic [DUR_W-1:0] ticks;
    logic             last;
  } interval_t;

  // Receiver stall patterns, switched at random intervals.
  typedef enum logic [1:0] {
    RX_FREE,
    RX_COIN,
    RX_SPARSE,
    RX_EVERY_THIRD
  } rx_mode_t;

  // Expected lamp intervals for every accepted character, oldest first.
  class lamp_schedule;
    logic [15:0] unit_ticks;
    interval_t   expected_intervals[$];
    int          failures;

    function new();
      unit_ticks = UNIT_TICKS_RESET;
      failures   = 0;
    endfunction

    // Dots and dashes of each letter, first element first.
    function string morse_pattern(input logic [4:0] idx);
      case (idx)
        5'd0:  return ".-";
        5'd1:  return "-...";
        5'd2:  return "-.-.";
        5'd3:  return "-..";
        5'd4:  return ".";
        5'd5:  return "..-.";
        5'd6:  return "--.";
        5'd7:  return "....";
        5'd8:  return "..";
        5'd9:  return ".---";
        5'd10: return "-.-";
        5'd11: return ".-..";
        5'd12: return "--";
        5'd13: return "-.";
        5'd14: return "---";
        5'd15: return ".--.";
        5'd16: return "--.-";
        5'd17: return ".-.";
        5'd18: return "...";
        5'd19: return "-";
        5'd20: return "..-";
        5'd21: return "...-";
        5'd22: return ".--";
        5'd23: return "-..-";
        5'd24: return "-.--";
        default: return "--..";
      endcase
    endfunction

    function void queue_interval(input logic lamp, input int units, input logic last);
      logic [31:0] product;
      interval_t   iv;
      product  = units * unit_ticks;
      iv.lamp  = lamp;
      iv.ticks = product[DUR_W-1:0];
      iv.last  = last;
      expected_intervals.push_back(iv);
    endfunction

    function void add_char(input logic [7:0] c);
      string pat;
      if (c >= FIRST_LETTER && c <= LAST_LETTER) begin
        pat = morse_pattern(5'(c - FIRST_LETTER));
        for (int i = 0; i < pat.len(); i++) begin
          queue_interval(1'b1, (pat[i] == "-") ? 2 : 1, 1'b0);
          queue_interval(1'b0, 1, 1'b0);
        end
      end else begin
        queue_interval(1'b0, 4, 1'b0);
      end
      queue_interval(1'b0, 2, 1'b1);
    endfunction

    function void check_interval(input logic lamp, input logic [DUR_W-1:0] ticks,
                                 input logic last);
      interval_t want;
      if (expected_intervals.size() == 0) begin
        $error("unexpected interval: lamp_on %0d duration_ticks %0d last %0d",
               lamp, ticks, last);
        failures++;
        return;
      end
      want = expected_intervals.pop_front();
      if (lamp !== want.lamp) begin
        $error("lamp_on: expected %0d, actual %0d", want.lamp, lamp);
        failures++;
      end
      if (ticks !== want.ticks) begin
        $error("duration_ticks: expected %0d, actual %0d", want.ticks, ticks);
        failures++;
      end
      if (last !== want.last) begin
        $error("last: expected %0d, actual %0d", want.last, last);
        failures++;
      end
    endfunction

    function int pending();
      return expected_intervals.size();
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst;
  logic             unit_ticks_we;
  logic [15:0]      unit_ticks_data;
  logic [7:0]       char_code;
  logic             in_valid;
  logic             in_ready;
  logic             lamp_on;
  logic [DUR_W-1:0] duration_ticks;
  logic             last;
  logic             out_valid;
  logic             out_ready;

  // Set by the stimulus to ask the receiver for one long hold-off.
  bit hold_req = 1'b0;

  lamp_schedule sched = new();

  morse_letter_encoder u_dut (
    .clk             (clk),
    .rst             (rst),
    .unit_ticks_we   (unit_ticks_we),
    .unit_ticks_data (unit_ticks_data),
    .char_code       (char_code),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .lamp_on         (lamp_on),
    .duration_ticks  (duration_ticks),
    .last            (last),
    .out_valid       (out_valid),
    .out_ready       (out_ready)
  );

  always #2 clk = ~clk;

  // Check every output beat against the oldest expected interval.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sched.check_interval(lamp_on, duration_ticks, last);
  end

  // Watchdog: end the run if no beat moves on either channel for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  // Receiver: switch between stall patterns at random intervals, and
  // honor one long hold-off on request while the sender keeps pushing.
  initial begin : receiver
    rx_mode_t mode;
    int       phase;
    out_ready = 1'b0;
    phase     = 0;
    forever begin
      mode = rx_mode_t'($urandom_range(0, 3));
      repeat ($urandom_range(20, 80)) begin
        @(negedge clk);
        phase++;
        if (hold_req) begin
          out_ready = 1'b0;
          repeat (HOLD_CYCLES) @(negedge clk);
          hold_req = 1'b0;
        end
        case (mode)
          RX_FREE:        out_ready = 1'b1;
          RX_COIN:        out_ready = ($urandom_range(0, 1) == 1);
          RX_SPARSE:      out_ready = ($urandom_range(0, 3) == 0);
          RX_EVERY_THIRD: out_ready = (phase % 3 != 0);
          default:        out_ready = 1'b1;
        endcase
      end
    end
  end

  // Offer one character and hold it until the block takes the beat. Leave
  // in_valid high afterwards; the next beat or a gap decides what follows.
  task automatic send_char(input logic [7:0] c);
    @(negedge clk);
    char_code = c;
    in_valid  = 1'b1;
    do @(posedge clk); while (!in_ready);
    sched.add_char(c);
  endtask

  // Drop valid for a number of cycles; zero keeps the beats back to back.
  task automatic sender_gap(input int cycles);
    if (cycles > 0) begin
      @(negedge clk);
      in_valid  = 1'b0;
      char_code = 8'($urandom_range(0, 255));
      repeat (cycles - 1) @(negedge clk);
    end
  endtask

  // Mostly letters so the element sequencer gets a workout; the rest any byte.
  function automatic logic [7:0] pick_char();
    if ($urandom_range(0, 9) < 7)
      return FIRST_LETTER + 8'($urandom_range(0, 25));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_random(input int count);
    int left;
    int burst;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 8);
      if (burst > left) burst = left;
      repeat (burst) send_char(pick_char());
      left -= burst;
      // A third of the time run straight into the next burst.
      if ($urandom_range(0, 2) == 0)
        sender_gap(0);
      else
        sender_gap($urandom_range(1, 15));
    end
  endtask

  // Hold the sender until every expected interval has come out, then let
  // the sequencer settle before anything else touches it.
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (sched.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_unit_ticks(input logic [15:0] value);
    @(negedge clk);
    unit_ticks_we   = 1'b1;
    unit_ticks_data = value;
    @(negedge clk);
    unit_ticks_we   = 1'b0;
    sched.unit_ticks = value;
  endtask

  initial begin : stimulus
    logic [7:0]  directed_chars[$];
    logic [15:0] unit_settings[$];

    rst             = 1'b1;
    unit_ticks_we   = 1'b0;
    unit_ticks_data = 16'd0;
    char_code       = 8'd0;
    in_valid        = 1'b0;

    repeat (11) @(negedge clk);
    rst = 1'b0;

    // Directed: byte extremes, bytes just outside the letter range, upper
    // case, and letters covering short, long, all-dot and all-dash codes.
    directed_chars = '{8'h00, 8'hFF, 8'h60, 8'h7B, 8'h41, 8'h5A, 8'h20,
                       8'h61, 8'h7A, 8'h65, 8'h74, 8'h68, 8'h6F, 8'h6B,
                       8'h78, 8'h71, 8'h79, 8'h62, 8'h63, 8'h6A, 8'h6D};
    foreach (directed_chars[i]) send_char(directed_chars[i]);
    sender_gap(3);

    // Reset unit length first, with random traffic.
    send_random(20);

    // Back the block up: the receiver holds off while beats keep coming.
    drain();
    hold_req = 1'b1;
    repeat (12) send_char(pick_char());
    drain();

    // Sweep unit length: smallest nonzero, largest, zero (all durations
    // collapse to zero), one random value, then back to reset.
    unit_settings = '{16'd1, 16'hFFFF, 16'd0, 16'($urandom_range(2, 65534)),
                      UNIT_TICKS_RESET};
    foreach (unit_settings[i]) begin
      write_unit_ticks(unit_settings[i]);
      send_random((i == 0 || i == 1) ? 16 : 12);
      drain();
    end

    if (sched.failures == 0 && sched.pending() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
